// ===== hw/rtl/sap_pkg.sv =====
package sap_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_DETECT = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam int IN_COORD_W    = 16;
  localparam int ID_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int PAIR_MAP_W    = 28;
  localparam int PRESENT_MAP_W = 8;

  typedef struct packed {
    logic load_req;
    logic add_wr;
    logic add_fin;
    logic scan_wr;
    logic scan_fin;
    logic sort_lat_t;
    logic sort_lat_box;
    logic rd_prev;
    logic sort_cmp;
    logic sort_set;
    logic sort_put;
    logic out_load;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic st_fail;
    logic cnt_zero;
    logic cnt_lt2;
    logic add_last;
    logic scan_last;
    logic i_zero;
    logic lt;
    logic ev_set;
    logic t_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/sap_dp.sv =====
module sap_dp import sap_pkg::*; #(
  parameter int MAX_OBJECTS = 8,
  parameter int COORD_BITS  = 16,
  parameter int AXES        = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_ctrl_t                     ctrl,
  output dp_stat_t                     stat,
  input  logic [1:0]                   in_command,
  input  logic [ID_W-1:0]              in_object_id,
  input  logic signed [IN_COORD_W-1:0] in_min_x,
  input  logic signed [IN_COORD_W-1:0] in_min_y,
  input  logic signed [IN_COORD_W-1:0] in_min_z,
  input  logic signed [IN_COORD_W-1:0] in_max_x,
  input  logic signed [IN_COORD_W-1:0] in_max_y,
  input  logic signed [IN_COORD_W-1:0] in_max_z,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [STATUS_W-1:0]          out_status,
  output logic [PAIR_MAP_W-1:0]        out_pair_map,
  output logic [PRESENT_MAP_W-1:0]     out_present_map
);

  localparam int SLOTS = 2 * MAX_OBJECTS;
  localparam int NP    = MAX_OBJECTS * (MAX_OBJECTS - 1) / 2;
  localparam int OW    = $clog2(MAX_OBJECTS);
  localparam int KW    = $clog2(SLOTS + 1);
  localparam int AXW   = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DEPTH = AXES * SLOTS;
  localparam int EAW   = $clog2(DEPTH);

  typedef struct packed {
    logic [COORD_BITS-1:0] value;
    logic [OW-1:0]         owner;
    logic                  upper;
  } ent_t;

  typedef logic [2*AXES-1:0][COORD_BITS-1:0] box_t;

  ent_t ep_mem [DEPTH];
  box_t bx_mem [MAX_OBJECTS];

  ent_t              rd_q_r, t_ent_r;
  box_t              box_q_r, tbox_r, req_box_r;
  cmd_t              req_cmd_r;
  logic [ID_W-1:0]   req_id_r;
  logic [1:0]        st_r;
  logic [KW-1:0]     cnt_r, k_r, i_r, kept_r;
  logic [AXW-1:0]    ax_r;
  logic [OW-1:0]     p_own_r;
  logic [MAX_OBJECTS-1:0] present_r;
  logic [NP-1:0]     pair_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [PAIR_MAP_W-1:0]    out_pair_r;
  logic [PRESENT_MAP_W-1:0] out_present_r;

  logic [COORD_BITS-1:0] lo_all [3];
  logic [COORD_BITS-1:0] hi_all [3];
  logic [OW-1:0]   id_own, in_own, ev_b;
  logic            in_ok, in_present, ax_last, lt, overlap;
  logic [1:0]      st_nxt;
  logic [KW-1:0]   cnt_m1, rd_idx;
  logic [EAW-1:0]  rd_addr, wr_addr;
  ent_t            wr_data;
  logic            wr_en, box_wr;
  logic [NP-1:0]   ev_mask, rem_mask, pair_nxt;
  logic [PAIR_MAP_W-1:0]    pair_ext;
  logic [PRESENT_MAP_W-1:0] present_ext;

  function automatic logic [EAW-1:0] ea(input logic [AXW-1:0] ax, input logic [KW-1:0] idx);
    ea = EAW'(int'(ax) * SLOTS + int'(idx));
  endfunction

  assign lo_all[0] = COORD_BITS'(in_min_x);
  assign lo_all[1] = COORD_BITS'(in_min_y);
  assign lo_all[2] = COORD_BITS'(in_min_z);
  assign hi_all[0] = COORD_BITS'(in_max_x);
  assign hi_all[1] = COORD_BITS'(in_max_y);
  assign hi_all[2] = COORD_BITS'(in_max_z);

  assign id_own     = OW'(req_id_r);
  assign in_own     = OW'(in_object_id);
  assign in_ok      = int'(in_object_id) < MAX_OBJECTS;
  assign in_present = present_r[in_own];
  assign ax_last    = ax_r == AXW'(AXES - 1);
  assign cnt_m1     = KW'(cnt_r - 1'b1);
  assign lt         = $signed(t_ent_r.value) < $signed(rd_q_r.value);

  always_comb begin
    st_nxt = ST_DONE;
    if (cmd_t'(in_command) != CMD_DETECT) begin
      if (!in_ok) begin
        st_nxt = ST_ABSENT;
      end else if (cmd_t'(in_command) == CMD_ADD) begin
        st_nxt = in_present ? ST_DUP : ST_DONE;
      end else begin
        st_nxt = in_present ? ST_DONE : ST_ABSENT;
      end
    end
  end

  always_comb begin
    overlap = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if ($signed(tbox_r[a]) > $signed(box_q_r[AXES+a]) ||
          $signed(box_q_r[a]) > $signed(tbox_r[AXES+a])) begin
        overlap = 1'b0;
      end
    end
  end

  assign ev_b = ctrl.sort_set ? p_own_r : rd_q_r.owner;

  always_comb begin
    int j;
    ev_mask  = '0;
    rem_mask = '0;
    for (int hh = 1; hh < MAX_OBJECTS; hh++) begin
      for (int ll = 0; ll < hh; ll++) begin
        j = hh * (hh - 1) / 2 + ll;
        ev_mask[j] = (t_ent_r.owner == OW'(hh) && ev_b == OW'(ll)) ||
                     (t_ent_r.owner == OW'(ll) && ev_b == OW'(hh));
        rem_mask[j] = id_own == OW'(hh) || id_own == OW'(ll);
      end
    end
  end

  always_comb begin
    pair_nxt = pair_r;
    if (ctrl.scan_fin && req_cmd_r == CMD_REMOVE) begin
      pair_nxt = pair_r & ~rem_mask;
    end else if (ctrl.sort_cmp && lt && t_ent_r.upper && !rd_q_r.upper) begin
      pair_nxt = pair_r & ~ev_mask;
    end else if (ctrl.sort_set && overlap) begin
      pair_nxt = pair_r | ev_mask;
    end
  end

  assign rd_idx  = ctrl.rd_prev ? KW'(i_r - 1'b1) : k_r;
  assign rd_addr = ea(ax_r, rd_idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ea(ax_r, k_r);
    wr_data = rd_q_r;
    if (ctrl.add_wr) begin
      wr_en         = 1'b1;
      wr_addr       = ea(ax_r, KW'(cnt_r + k_r));
      wr_data.value = k_r[0] ? req_box_r[AXES+int'(ax_r)] : req_box_r[int'(ax_r)];
      wr_data.owner = id_own;
      wr_data.upper = k_r[0];
    end else if (ctrl.scan_wr) begin
      if (req_cmd_r == CMD_UPDATE) begin
        wr_en         = rd_q_r.owner == id_own;
        wr_data.value = rd_q_r.upper ? req_box_r[AXES+int'(ax_r)] : req_box_r[int'(ax_r)];
      end else begin
        wr_en   = rd_q_r.owner != id_own;
        wr_addr = ea(ax_r, kept_r);
      end
    end else if (ctrl.sort_cmp) begin
      wr_en   = lt;
      wr_addr = ea(ax_r, i_r);
    end else if (ctrl.sort_put) begin
      wr_en   = 1'b1;
      wr_addr = ea(ax_r, i_r);
      wr_data = t_ent_r;
    end
  end

  assign box_wr = ctrl.add_fin || (ctrl.scan_fin && req_cmd_r == CMD_UPDATE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ep_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= ep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (box_wr) begin
      bx_mem[id_own] <= req_box_r;
    end
    box_q_r <= bx_mem[rd_q_r.owner];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      req_cmd_r <= cmd_t'(in_command);
      req_id_r  <= in_object_id;
      st_r      <= st_nxt;
      ax_r      <= '0;
      k_r       <= (cmd_t'(in_command) == CMD_DETECT) ? KW'(1) : '0;
      kept_r    <= '0;
      for (int a = 0; a < AXES; a++) begin
        req_box_r[a]      <= lo_all[a];
        req_box_r[AXES+a] <= hi_all[a];
      end
    end
    if (ctrl.add_wr) begin
      if (k_r[0]) begin
        k_r  <= '0;
        ax_r <= ax_r + 1'b1;
      end else begin
        k_r <= KW'(1);
      end
    end
    if (ctrl.scan_wr) begin
      if (k_r == cnt_m1 && !ax_last) begin
        k_r    <= '0;
        ax_r   <= ax_r + 1'b1;
        kept_r <= '0;
      end else begin
        k_r <= k_r + 1'b1;
        if (rd_q_r.owner != id_own) begin
          kept_r <= kept_r + 1'b1;
        end
      end
    end
    if (ctrl.sort_lat_t) begin
      t_ent_r <= rd_q_r;
      i_r     <= k_r;
    end
    if (ctrl.sort_lat_box) begin
      tbox_r <= box_q_r;
    end
    if (ctrl.sort_cmp && lt) begin
      i_r     <= i_r - 1'b1;
      p_own_r <= rd_q_r.owner;
    end
    if (ctrl.sort_put) begin
      if (k_r == cnt_m1) begin
        k_r  <= KW'(1);
        ax_r <= ax_r + 1'b1;
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
    if (ctrl.out_load) begin
      out_status_r  <= st_r;
      out_pair_r    <= pair_ext;
      out_present_r <= present_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      present_r   <= '0;
      pair_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pair_r <= pair_nxt;
      if (ctrl.add_fin) begin
        cnt_r     <= KW'(cnt_r + 2'd2);
        present_r <= present_r | (MAX_OBJECTS'(1) << id_own);
      end
      if (ctrl.scan_fin && req_cmd_r == CMD_REMOVE) begin
        cnt_r     <= kept_r;
        present_r <= present_r & ~(MAX_OBJECTS'(1) << id_own);
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  if (NP >= PAIR_MAP_W) begin : g_pair_cut
    assign pair_ext = pair_r[PAIR_MAP_W-1:0];
  end else begin : g_pair_ext
    assign pair_ext = {{(PAIR_MAP_W-NP){1'b0}}, pair_r};
  end

  if (MAX_OBJECTS >= PRESENT_MAP_W) begin : g_pres_cut
    assign present_ext = present_r[PRESENT_MAP_W-1:0];
  end else begin : g_pres_ext
    assign present_ext = {{(PRESENT_MAP_W-MAX_OBJECTS){1'b0}}, present_r};
  end

  assign stat.cmd       = req_cmd_r;
  assign stat.st_fail   = st_r != ST_DONE;
  assign stat.cnt_zero  = cnt_r == '0;
  assign stat.cnt_lt2   = cnt_r < KW'(2);
  assign stat.add_last  = k_r[0] && ax_last;
  assign stat.scan_last = (k_r == cnt_m1) && ax_last;
  assign stat.i_zero    = i_r == '0;
  assign stat.lt        = lt;
  assign stat.ev_set    = lt && !t_ent_r.upper && rd_q_r.upper &&
                          (t_ent_r.owner != rd_q_r.owner);
  assign stat.t_last    = (k_r == cnt_m1) && ax_last;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pair_map    = out_pair_r;
  assign out_present_map = out_present_r;

endmodule

// ===== hw/rtl/sap_ctrl.sv =====
module sap_ctrl import sap_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECIDE = 15'b000000000000010,
    S_ADD    = 15'b000000000000100,
    S_ADDF   = 15'b000000000001000,
    S_SCANR  = 15'b000000000010000,
    S_SCANW  = 15'b000000000100000,
    S_SCANF  = 15'b000000001000000,
    S_RT     = 15'b000000010000000,
    S_LT     = 15'b000000100000000,
    S_LB     = 15'b000001000000000,
    S_RP     = 15'b000010000000000,
    S_CMP    = 15'b000100000000000,
    S_SET    = 15'b001000000000000,
    S_PUT    = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_req = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.st_fail) begin
          state_nxt = S_OUT;
        end else begin
          case (stat.cmd)
            CMD_ADD:    state_nxt = S_ADD;
            CMD_UPDATE,
            CMD_REMOVE: state_nxt = stat.cnt_zero ? S_SCANF : S_SCANR;
            CMD_DETECT: state_nxt = stat.cnt_lt2 ? S_OUT : S_RT;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        ctrl.add_wr = 1'b1;
        if (stat.add_last) begin
          state_nxt = S_ADDF;
        end
      end
      S_ADDF: begin
        ctrl.add_fin = 1'b1;
        state_nxt    = S_OUT;
      end
      S_SCANR: begin
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        ctrl.scan_wr = 1'b1;
        state_nxt    = stat.scan_last ? S_SCANF : S_SCANR;
      end
      S_SCANF: begin
        ctrl.scan_fin = 1'b1;
        state_nxt     = S_OUT;
      end
      S_RT: begin
        state_nxt = S_LT;
      end
      S_LT: begin
        ctrl.sort_lat_t = 1'b1;
        state_nxt       = S_LB;
      end
      S_LB: begin
        ctrl.sort_lat_box = 1'b1;
        state_nxt         = S_RP;
      end
      S_RP: begin
        ctrl.rd_prev = 1'b1;
        state_nxt    = stat.i_zero ? S_PUT : S_CMP;
      end
      S_CMP: begin
        ctrl.sort_cmp = 1'b1;
        if (!stat.lt) begin
          state_nxt = S_PUT;
        end else if (stat.ev_set) begin
          state_nxt = S_SET;
        end else begin
          state_nxt = S_RP;
        end
      end
      S_SET: begin
        ctrl.sort_set = 1'b1;
        state_nxt     = S_RP;
      end
      S_PUT: begin
        ctrl.sort_put = 1'b1;
        state_nxt     = stat.t_last ? S_OUT : S_RT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sweep_and_prune_broad_phase.sv =====
// One request at a time; the next is taken once the result is in the output register.
// Add writes both endpoints on each axis, then the box. Update/remove read, then write each
// axis entry (one read, one write per entry). Detect insertion-sorts each axis: it latches an
// endpoint and its box, shifts it past greater earlier ends, setting or clearing pairs.
// Reset (rst_n low, synchronous) clears counts, object and pair maps and the output valid;
// endpoint and box memories need no clearing.
module sweep_and_prune_broad_phase import sap_pkg::*; #(
  parameter int MAX_OBJECTS = 8,
  parameter int COORD_BITS  = 16,
  parameter int AXES        = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [ID_W-1:0]              in_object_id,
  input  logic signed [IN_COORD_W-1:0] in_min_x,
  input  logic signed [IN_COORD_W-1:0] in_min_y,
  input  logic signed [IN_COORD_W-1:0] in_min_z,
  input  logic signed [IN_COORD_W-1:0] in_max_x,
  input  logic signed [IN_COORD_W-1:0] in_max_y,
  input  logic signed [IN_COORD_W-1:0] in_max_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_W-1:0]          out_status,
  output logic [PAIR_MAP_W-1:0]        out_pair_map,
  output logic [PRESENT_MAP_W-1:0]     out_present_map
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  sap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sap_dp #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .COORD_BITS  (COORD_BITS),
    .AXES        (AXES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_command      (in_command),
    .in_object_id    (in_object_id),
    .in_min_x        (in_min_x),
    .in_min_y        (in_min_y),
    .in_min_z        (in_min_z),
    .in_max_x        (in_max_x),
    .in_max_y        (in_max_y),
    .in_max_z        (in_max_z),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pair_map    (out_pair_map),
    .out_present_map (out_present_map)
  );

endmodule
